// ===== src/range_to_prefix_expander_assert.svh =====
// Assertion macros shared by the range-to-prefix expander RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef RANGE_TO_PREFIX_EXPANDER_ASSERT_SVH
`define RANGE_TO_PREFIX_EXPANDER_ASSERT_SVH
`ifndef SYNTHESIS
`define RTPE_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTPE_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);
`else
`define RTPE_ASSERT(name, clk, rst_n, prop, msg)
`define RTPE_ASSERT_NEXT(name, clk, rst_n, cond, expr, msg)
`endif
`endif

// ===== src/rtpe_pkg.sv =====
// Package of the range-to-prefix expander: field widths, limits, state encoding
// and the command and status structs between controller and datapath.
package rtpe_pkg;

	localparam int BND_W       = 33;
	localparam int LABEL_W     = 32;
	localparam int BASE_W      = 32;
	localparam int LEN_W       = 6;
	localparam int MAX_RESULTS = 62;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EXPAND
	} rtpe_state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
	} rtpe_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic out_free;
		logic last;
	} rtpe_sts_t;

endpackage

// ===== src/rtpe_if.sv =====
// Valid/ready channel interfaces for the boundary input and the prefix output.
// Depends on rtpe_pkg for the field widths.
interface rtpe_in_if import rtpe_pkg::*;;
	logic               valid;
	logic               ready;
	logic [BND_W-1:0]   boundary;
	logic               emit_enable;
	logic [LABEL_W-1:0] label;

	modport source(output valid, output boundary, output emit_enable, output label,
		input ready);
	modport sink(input valid, input boundary, input emit_enable, input label,
		output ready);
endinterface

interface rtpe_out_if import rtpe_pkg::*;;
	logic               valid;
	logic               ready;
	logic [BASE_W-1:0]  prefix_base;
	logic [LEN_W-1:0]   prefix_length;
	logic [LABEL_W-1:0] range_label;
	logic               last_of_run;

	modport source(output valid, output prefix_base, output prefix_length,
		output range_label, output last_of_run, input ready);
	modport sink(input valid, input prefix_base, input prefix_length,
		input range_label, input last_of_run, output ready);
endinterface

// ===== src/rtpe_ctrl.sv =====
// Controller of the range-to-prefix expander: sequences input acceptance and
// the per-prefix steps of the datapath. Depends on rtpe_pkg.
module rtpe_ctrl import rtpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rtpe_sts_t sts,
	output rtpe_cmd_t cmd
);

	rtpe_state_t state_q;
	rtpe_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid;
				cmd.start = in_valid && sts.range_ok;
				if (in_valid && sts.range_ok) begin
					state_nxt = ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				cmd.step = sts.out_free;
				if (sts.out_free && sts.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/rtpe_datapath.sv =====
// Datapath of the range-to-prefix expander: previous-boundary registers, the
// greedy cover step (cursor, remaining, count) and the output word register.
// Depends on rtpe_pkg.
module rtpe_datapath import rtpe_pkg::*; #(
	parameter int ADDR_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [BND_W-1:0]   boundary,
	input  logic               emit_enable,
	input  logic [LABEL_W-1:0] label,
	input  rtpe_cmd_t          cmd,
	output rtpe_sts_t          sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [BASE_W-1:0]  prefix_base,
	output logic [LEN_W-1:0]   prefix_length,
	output logic [LABEL_W-1:0] range_label,
	output logic               last_of_run
);

	localparam int CW       = (ADDR_WIDTH >= BND_W) ? BND_W : ADDR_WIDTH + 1;
	localparam int IDX_W    = $clog2(CW);
	localparam int SH_STEPS = $clog2(CW);

	logic [CW-1:0]      bnd_sat;
	logic [CW-1:0]      prev_bnd_q;
	logic               prev_en_q;
	logic [LABEL_W-1:0] prev_label_q;
	logic [LABEL_W-1:0] run_label_q;
	logic               primed_q;
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [BASE_W-1:0]  base_q;
	logic [LEN_W-1:0]   len_q;
	logic [LABEL_W-1:0] olabel_q;
	logic               last_q;

	logic [CW-1:0]      lowbit;
	logic [CW-1:0]      smear;
	logic [CW-1:0]      msb;
	logic [CW-1:0]      blk;
	logic [IDX_W-1:0]   blk_idx;
	logic [CW-1:0]      rem_nxt;
	logic               step_last;

	if (ADDR_WIDTH < BND_W) begin : g_sat
		localparam logic [BND_W-1:0] SPACE = BND_W'(1) << ADDR_WIDTH;
		assign bnd_sat = (boundary > SPACE) ? CW'(SPACE) : CW'(boundary);
	end else begin : g_nosat
		assign bnd_sat = CW'(boundary);
	end

	// Largest aligned block at the cursor that still fits in the remainder.
	assign lowbit = cursor_q & (~cursor_q + CW'(1));

	always_comb begin
		smear = rem_q;
		for (int i = 0; i < SH_STEPS; i++) begin
			smear = smear | (smear >> (1 << i));
		end
	end

	assign msb = smear & ~(smear >> 1);
	assign blk = (lowbit != '0 && lowbit <= rem_q) ? lowbit : msb;

	always_comb begin
		blk_idx = '0;
		for (int i = 0; i < CW; i++) begin
			if (blk[i]) begin
				blk_idx = IDX_W'(i);
			end
		end
	end

	assign rem_nxt   = rem_q - blk;
	assign step_last = (rem_nxt == '0) || (cnt_q == CNT_W'(MAX_RESULTS - 1));

	assign sts.range_ok = primed_q && prev_en_q && (bnd_sat > prev_bnd_q);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last     = step_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_bnd_q  <= '0;
			prev_en_q   <= 1'b0;
			primed_q    <= 1'b0;
			cursor_q    <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_bnd_q <= bnd_sat;
				prev_en_q  <= emit_enable;
				primed_q   <= 1'b1;
			end
			if (cmd.start) begin
				cursor_q <= prev_bnd_q;
				rem_q    <= bnd_sat - prev_bnd_q;
				cnt_q    <= '0;
			end else if (cmd.step) begin
				cursor_q <= cursor_q + blk;
				rem_q    <= rem_nxt;
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The label of the range being expanded is held apart from the previous
	// label, which the same start cycle already replaces with the new word's.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prev_label_q <= label;
		end
		if (cmd.start) begin
			run_label_q <= prev_label_q;
		end
		if (cmd.step) begin
			base_q   <= BASE_W'(cursor_q);
			len_q    <= LEN_W'(ADDR_WIDTH) - LEN_W'(blk_idx);
			olabel_q <= run_label_q;
			last_q   <= step_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign prefix_base   = base_q;
	assign prefix_length = len_q;
	assign range_label   = olabel_q;
	assign last_of_run   = last_q;

endmodule

// ===== src/range_to_prefix_expander.sv =====
// Top level of the range-to-prefix expander; instantiates rtpe_ctrl and
// rtpe_datapath and depends on rtpe_pkg, rtpe_if and the assertion header.
//
// The block takes a sorted stream of range boundaries and, for each range whose
// opening boundary had emit_enable set, emits the minimal aligned prefix cover
// of [previous boundary, boundary), lowest address first, with last_of_run on
// the final word of each run. A range that expands then occupies the block while
// the single greedy step unit retires its prefixes, one prefix each cycle that the
// output side is free: at most 2*ADDR_WIDTH-2 prefixes, capped at 62 (62 at the
// default width). No input is taken while a range is being expanded.
`include "range_to_prefix_expander_assert.svh"

module range_to_prefix_expander import rtpe_pkg::*; #(
	parameter int ADDR_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	rtpe_in_if.sink     din,
	rtpe_out_if.source  dout
);

	rtpe_cmd_t cmd;
	rtpe_sts_t sts;

	rtpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtpe_datapath #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.boundary      (din.boundary),
		.emit_enable   (din.emit_enable),
		.label         (din.label),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (dout.ready),
		.out_valid     (dout.valid),
		.prefix_base   (dout.prefix_base),
		.prefix_length (dout.prefix_length),
		.range_label   (dout.range_label),
		.last_of_run   (dout.last_of_run)
	);

	`RTPE_ASSERT(a_len_range, clk, arst_n, dout.valid |-> dout.prefix_length <= ADDR_WIDTH, "prefix length beyond address width")
	`RTPE_ASSERT(a_mid_run_busy, clk, arst_n, (dout.valid && dout.ready && !dout.last_of_run) |-> !din.ready, "input taken in the middle of a run")
	`RTPE_ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.start, !din.ready, "expansion started but input still ready")

endmodule

// ===== dv/tb_range_to_prefix_expander.sv =====
// Self-checking testbench for range_to_prefix_expander: drives mostly ascending boundary words
// and checks every emitted prefix word against an in-bench greedy prefix cover.
// Depends on rtpe_pkg, rtpe_if and the RTL of the expander.
module tb_range_to_prefix_expander import rtpe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W = 32;
	localparam logic [BND_W-1:0] SPACE = 33'h1_0000_0000;
	localparam logic [BND_W-1:0] BND_MAX = 33'h1_FFFF_FFFF;
	localparam int MAX_PRINTED = 50;

	typedef struct {
		logic [BND_W-1:0]   bnd;
		logic               en;
		logic [LABEL_W-1:0] lab;
		logic               wait_idle;
	} boundary_word_t;

	typedef struct {
		logic [BASE_W-1:0]  base;
		logic [LEN_W-1:0]   len;
		logic [LABEL_W-1:0] lab;
		logic               last;
	} prefix_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	rtpe_in_if  din_if();
	rtpe_out_if dout_if();

	range_to_prefix_expander dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	boundary_word_t pending_q[$];
	prefix_word_t   prefix_q[$];
	int             mismatch_count = 0;
	int             prefixes_seen = 0;

	logic [BND_W-1:0]   last_bnd = '0;
	logic               last_en = 1'b0;
	logic [LABEL_W-1:0] last_lab = '0;
	logic               primed = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Greedy aligned cover of the range closed by this boundary, lowest address first.
	function automatic void expand_range(boundary_word_t w);
		logic [BND_W-1:0] top;
		logic [BND_W-1:0] at;
		logic [BND_W-1:0] left;
		logic [63:0]      span;
		int               b;
		int               n;
		prefix_word_t     p;
		top = (w.bnd > SPACE) ? SPACE : w.bnd;
		if (primed && last_en && top > last_bnd) begin
			at = last_bnd;
			left = top - last_bnd;
			n = 0;
			while (left != 0 && n < MAX_RESULTS) begin
				b = 0;
				while (b < ADDR_W && !at[b])
					b++;
				while (b > 0 && (64'd1 << b) > {31'b0, left})
					b--;
				span = 64'd1 << b;
				p.base = at[BASE_W-1:0];
				p.len = LEN_W'(ADDR_W - b);
				p.lab = last_lab;
				at = at + span[BND_W-1:0];
				left = left - span[BND_W-1:0];
				n++;
				p.last = (left == 0 || n == MAX_RESULTS);
				prefix_q.push_back(p);
			end
		end
		last_bnd = top;
		last_en = w.en;
		last_lab = w.lab;
		primed = 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("ERROR at %0t, word %0d, %s: got 0x%0h, expected 0x%0h",
				$realtime, prefixes_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_boundary(logic [BND_W-1:0] bnd, logic en, logic [LABEL_W-1:0] lab,
		logic wait_idle);
		boundary_word_t w;
		w.bnd = bnd;
		w.en = en;
		w.lab = lab;
		w.wait_idle = wait_idle;
		pending_q.push_back(w);
	endtask

	boundary_word_t on_wire;
	int             burst_left = 0;
	int             gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		boundary_word_t w;
		logic           offer;
		if (!arst_n) begin
			din_if.valid <= 1'b0;
			din_if.boundary <= '0;
			din_if.emit_enable <= 1'b0;
			din_if.label <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (din_if.valid && din_if.ready)
				expand_range(on_wire);
			if (!din_if.valid || din_if.ready) begin
				offer = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_q.size() != 0 &&
						(!pending_q[0].wait_idle || prefix_q.size() == 0)) begin
					offer = 1'b1;
					w = pending_q.pop_front();
					on_wire = w;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
				din_if.valid <= offer;
				if (offer) begin
					din_if.boundary <= w.bnd;
					din_if.emit_enable <= w.en;
					din_if.label <= w.lab;
				end
			end
		end
	end

	logic [7:0] stall_mask;
	int         mask_age;
	int         hold_left;
	logic       hold_done;

	always @(posedge clk or negedge arst_n) begin
		prefix_word_t want;
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
			stall_mask = 8'hFF;
			mask_age = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (dout_if.valid && dout_if.ready) begin
				if (prefix_q.size() == 0) begin
					report_mismatch("unexpected word, prefix_base", dout_if.prefix_base, 0);
				end else begin
					want = prefix_q.pop_front();
					if (dout_if.prefix_base !== want.base)
						report_mismatch("prefix_base", dout_if.prefix_base, want.base);
					if (dout_if.prefix_length !== want.len)
						report_mismatch("prefix_length", dout_if.prefix_length, want.len);
					if (dout_if.range_label !== want.lab)
						report_mismatch("range_label", dout_if.range_label, want.lab);
					if (dout_if.last_of_run !== want.last)
						report_mismatch("last_of_run", dout_if.last_of_run, want.last);
				end
				prefixes_seen++;
			end
			if (!hold_done && prefixes_seen >= 40) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			mask_age++;
			if (mask_age == 64) begin
				mask_age = 0;
				stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
			end else begin
				stall_mask = {stall_mask[6:0], stall_mask[7]};
			end
			if (hold_left != 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= stall_mask[0];
			end
		end
	end

	initial begin
		logic [63:0]      cur;
		logic [63:0]      nxt;
		logic [63:0]      inc;
		logic [BND_W-1:0] bnd;
		int               sel;
		int               k;
		arst_n <= 1'b0;

		// Priming word, smallest range, empty, disabled and backward ranges.
		add_boundary(33'h0, 1'b1, 32'hA5A5_0001, 1'b0);
		add_boundary(33'h1, 1'b1, 32'h0000_0000, 1'b0);
		add_boundary(33'h1, 1'b0, 32'hFFFF_FFFF, 1'b0);
		add_boundary(SPACE, 1'b1, 32'h1234_5678, 1'b0);
		add_boundary(33'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
		// The whole address space as one prefix.
		add_boundary(SPACE, 1'b1, 32'h0000_0000, 1'b1);
		// The longest cover, then boundaries beyond the address space.
		add_boundary(33'h1, 1'b1, 32'h5A5A_5A5A, 1'b0);
		add_boundary(33'h0_FFFF_FFFF, 1'b1, 32'hC3C3_C3C3, 1'b0);
		add_boundary(BND_MAX, 1'b1, 32'h0F0F_0F0F, 1'b0);
		add_boundary(33'h1_0000_0001, 1'b1, 32'h8000_0000, 1'b1);
		add_boundary(33'h0_8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0);
		add_boundary(33'h0_8000_0100, 1'b1, 32'h0000_0001, 1'b0);
		add_boundary(33'h0_8000_0101, 1'b1, 32'hFFFF_FFFE, 1'b0);
		add_boundary(SPACE, 1'b0, 32'h3C3C_3C3C, 1'b0);

		// Mostly ascending boundaries with spans of every size, plus noise.
		cur = 64'h0;
		for (int i = 0; i < 196; i++) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				bnd = {1'($urandom_range(0, 1)), 32'($urandom)};
			end else if (sel == 1) begin
				bnd = cur[BND_W-1:0];
			end else if (cur >= {31'b0, SPACE} || sel == 2) begin
				bnd = {1'b0, 32'($urandom) >> $urandom_range(0, 31)};
			end else begin
				k = $urandom_range(0, 32);
				inc = ({32'($urandom), 32'($urandom)} & ((64'd1 << k) - 64'd1)) + 64'd1;
				nxt = cur + inc;
				if (nxt > {31'b0, BND_MAX})
					nxt = {31'b0, BND_MAX};
				bnd = nxt[BND_W-1:0];
			end
			cur = (bnd > SPACE) ? {31'b0, SPACE} : {31'b0, bnd};
			add_boundary(bnd, $urandom_range(0, 3) != 0, 32'($urandom), (i % 45) == 44);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() == 0 && !din_if.valid);
		wait (prefix_q.size() == 0);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/rtpe_pkg.sv
src/rtpe_if.sv
src/rtpe_ctrl.sv
src/rtpe_datapath.sv
src/range_to_prefix_expander.sv
dv/tb_range_to_prefix_expander.sv
